/* rtl/usoa_pkg.sv */
// Shared types, constants and helpers for the unique-owner slot allocator.
package usoa_pkg;

  // Field widths
  localparam int CAP_W   = 7;
  localparam int FUNC_W  = 3;
  localparam int OWNER_W = 16;
  localparam int SIDX_W  = 6;

  // Capacity register
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam int               CAP_MAX   = 127;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_ACTIVE_CAP = '0;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_RSV_FIRST = 3'd0;
  localparam logic [FUNC_W-1:0] FN_RSV_AT    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FREE_SLOT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FREE_LAST = 3'd3;
  localparam logic [FUNC_W-1:0] FN_QUERY     = 3'd4;

  // Status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [OWNER_W-1:0] owner_id;
    logic [SIDX_W-1:0]  slot_index;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [SIDX_W-1:0]  result_slot;
    logic [OWNER_W-1:0] result_owner;
    logic [CAP_W-1:0]   free_count;
    logic [CAP_W-1:0]   occupied_count;
  } rsp_t;

  // Register state handed from the configuration port to the engine
  typedef struct packed {
    logic             clear;
    logic [CAP_W-1:0] capacity;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_FETCH,
    ST_FINISH
  } state_t;

  // Assemble one result word
  function automatic rsp_t make_rsp(input logic status, input logic [CAP_W-1:0] slot,
                                    input logic [OWNER_W-1:0] owner,
                                    input logic [CAP_W-1:0] cap,
                                    input logic [CAP_W-1:0] count);
    rsp_t r;
    r.status         = status;
    r.result_slot    = slot[SIDX_W-1:0];
    r.result_owner   = owner;
    r.free_count     = cap - count;
    r.occupied_count = count;
    return r;
  endfunction

endpackage

/* rtl/unique_owner_slot_allocator.sv */
// Reserve operations run an owner scan over eff_cap table entries, where
//   eff_cap is the capacity saturated at the table depth (64 at 64 or more).
// Free-slot, free-last and query read one entry; an op rejected before the scan ends in EVAL.
// Throughput: one operation at a time; the next start transfer is taken in the strobe cycle.
// Reset clears the table, the held count and sets capacity to 64 with no clearing pass;
// a capacity write empties the table. The receiver cannot stall results.
module unique_owner_slot_allocator
  import usoa_pkg::*;
#(
  parameter int SLOTS      = 64,
  parameter int OWNER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  req_t               req,
  output logic               done,
  output rsp_t               rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Slots beyond the largest capacity value are never reachable
  localparam int DEPTH = (SLOTS < CAP_MAX) ? SLOTS : CAP_MAX;
  localparam int AW    = $clog2(DEPTH);

  cfg_t                  cfg;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [OWNER_BITS-1:0] rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [OWNER_BITS-1:0] wr_data;

  usoa_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  usoa_owner_ram #(
    .DEPTH (DEPTH),
    .WIDTH (OWNER_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  usoa_engine #(
    .DEPTH      (DEPTH),
    .OWNER_BITS (OWNER_BITS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (req),
    .cfg     (cfg),
    .busy    (busy),
    .done    (done),
    .rsp     (rsp),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

/* rtl/usoa_owner_ram.sv */
// Owner table: single-port-write, registered-read synchronous memory.
module usoa_owner_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/usoa_apb_regs.sv */
// APB register block holding the active capacity.
module usoa_apb_regs
  import usoa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic             hit;
  logic             wr_hit;
  logic [CAP_W-1:0] capacity;

  // Address decode on the word index
  assign hit    = (paddr[PADDR_W-1:2] == REG_ACTIVE_CAP);
  assign wr_hit = psel && penable && pwrite && hit;
  assign pready = 1'b1;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (wr_hit) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Read data and clear pulse to the engine
  always_comb begin
    prdata       = hit ? PDATA_W'(capacity) : '0;
    cfg.capacity = capacity;
    cfg.clear    = wr_hit;
  end

endmodule

/* rtl/usoa_engine.sv */
// Operation sequencer: held bits, held count, owner table scan and result register.
module usoa_engine
  import usoa_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int OWNER_BITS = 16,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  req_t                  req,
  input  cfg_t                  cfg,
  output logic                  busy,
  output logic                  done,
  output rsp_t                  rsp,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  logic [OWNER_BITS-1:0] rd_data,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [OWNER_BITS-1:0] wr_data
);

  localparam logic [CAP_W-1:0] LIM = CAP_W'(DEPTH);

  state_t state, state_next;

  // Latched operation
  logic [FUNC_W-1:0]     op_func;
  logic [OWNER_BITS-1:0] op_owner;
  logic [CAP_W-1:0]      tgt;

  // Table state
  logic [DEPTH-1:0] held;
  logic [CAP_W-1:0] held_count;

  // Scan pipeline
  logic [CAP_W-1:0] cnt;
  logic             p_vld;
  logic             p_held;
  logic             dup;
  logic             free_found;
  logic [CAP_W-1:0] free_slot;

  logic [CAP_W-1:0] cap;
  logic             tgt_in;
  logic             held_tgt;
  logic             room;
  logic             eval_ok;
  logic             is_rsv;
  logic             is_free;
  logic             issue;
  logic             scan_end;
  logic             rsv_ok;
  logic [CAP_W-1:0] rsv_slot;

  // Effective capacity saturates at the table depth
  assign cap = (cfg.capacity > LIM) ? LIM : cfg.capacity;

  // Precondition checks on the latched operation
  always_comb begin
    tgt_in   = (tgt < cap);
    held_tgt = tgt_in ? held[AW'(tgt)] : 1'b0;
    room     = (held_count < cap);
    is_rsv   = (op_func == FN_RSV_FIRST) || (op_func == FN_RSV_AT);
    is_free  = (op_func == FN_FREE_SLOT) || (op_func == FN_FREE_LAST);
    unique case (op_func)
      FN_RSV_FIRST: eval_ok = room;
      FN_RSV_AT:    eval_ok = tgt_in && !held_tgt && room;
      FN_FREE_SLOT: eval_ok = tgt_in && held_tgt;
      FN_FREE_LAST: eval_ok = (held_count != '0) && tgt_in && held_tgt;
      FN_QUERY:     eval_ok = tgt_in && held_tgt;
      default:      eval_ok = 1'b0;
    endcase
  end

  // Scan control and reservation decision
  always_comb begin
    issue    = (state == ST_SCAN) && (cnt < cap);
    scan_end = !issue && !p_vld;
    rsv_ok   = !dup && ((op_func == FN_RSV_AT) || free_found);
    rsv_slot = (op_func == FN_RSV_AT) ? tgt : free_slot;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (!eval_ok)    state_next = ST_IDLE;
        else if (is_rsv) state_next = ST_SCAN;
        else             state_next = ST_FETCH;
      end
      ST_SCAN: begin
        if (scan_end) state_next = ST_FINISH;
      end
      ST_FETCH:  state_next = ST_IDLE;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Memory strobes and handshake outputs
  always_comb begin
    busy    = (state != ST_IDLE);
    rd_en   = ((state == ST_EVAL) && eval_ok && !is_rsv) || issue;
    rd_addr = (state == ST_SCAN) ? AW'(cnt) : AW'(tgt);
    wr_en   = (state == ST_FINISH) && rsv_ok;
    wr_addr = AW'(rsv_slot);
    wr_data = op_owner;
  end

  // Datapath and table update
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      held       <= '0;
      held_count <= '0;
      p_vld      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg.clear) begin
        held       <= '0;
        held_count <= '0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op_func  <= req.func;
            op_owner <= OWNER_BITS'(req.owner_id);
            tgt      <= (req.func == FN_FREE_LAST) ? held_count - 1'b1
                                                   : CAP_W'(req.slot_index);
          end
        end
        ST_EVAL: begin
          cnt        <= '0;
          p_vld      <= 1'b0;
          dup        <= 1'b0;
          free_found <= 1'b0;
          if (!eval_ok) begin
            done <= 1'b1;
            rsp  <= make_rsp(STATUS_FAIL, '0, '0, cap, held_count);
          end
        end
        ST_SCAN: begin
          // issue one read per cycle, compare the entry read last cycle
          p_vld <= issue;
          if (issue) begin
            p_held <= held[AW'(cnt)];
            cnt    <= cnt + 1'b1;
            if (!held[AW'(cnt)] && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= cnt;
            end
          end
          if (p_vld && p_held && (rd_data == op_owner)) begin
            dup <= 1'b1;
          end
        end
        ST_FETCH: begin
          done <= 1'b1;
          if (is_free) begin
            held[AW'(tgt)] <= 1'b0;
            held_count     <= held_count - 1'b1;
            rsp <= make_rsp(STATUS_OK, tgt, OWNER_W'(rd_data), cap, held_count - 1'b1);
          end else begin
            rsp <= make_rsp(STATUS_OK, tgt, OWNER_W'(rd_data), cap, held_count);
          end
        end
        ST_FINISH: begin
          done <= 1'b1;
          if (rsv_ok) begin
            held[AW'(rsv_slot)] <= 1'b1;
            held_count          <= held_count + 1'b1;
            rsp <= make_rsp(STATUS_OK, rsv_slot, '0, cap, held_count + 1'b1);
          end else begin
            rsp <= make_rsp(STATUS_FAIL, '0, '0, cap, held_count);
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Occupancy never exceeds the active capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    held_count <= cap)
    else $error("held count above capacity");

  // A result only follows a deciding state
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EVAL || state == ST_FETCH || state == ST_FINISH))
    else $error("result strobe without a deciding state");

  // Successful reservation adds exactly one held slot
  a_rsv_inc: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == STATUS_OK) && is_rsv) |-> (held_count == $past(held_count) + 1))
    else $error("reservation did not increment count");

  // Successful free removes exactly one held slot
  a_free_dec: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == STATUS_OK) && is_free) |-> (held_count + 1 == $past(held_count)))
    else $error("free did not decrement count");
`endif

endmodule

/* sim/tb_unique_owner_slot_allocator.sv */
// Self-checking testbench for the unique-owner slot allocator.
`timescale 1ns / 100ps

module tb_unique_owner_slot_allocator;
  import usoa_pkg::*;

  localparam int NUM_SLOTS   = 64;
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 50;
  localparam int PHASE_CAP [PHASES] = '{64, 2, 127, 17, 1, 65, 0, 64, 5, 40, 3};

  // Codes the block does not define; they must be rejected
  localparam logic [FUNC_W-1:0] FN_RSVD5 = 3'd5;
  localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;

  localparam logic [PADDR_W-1:0] CAP_ADDR   = {REG_ACTIVE_CAP, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR = 3'd4;

  typedef enum logic {ROW_OP, ROW_CAP} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [CAP_W-1:0] cap_val;
    req_t             op;
    bit               typed;
    rsp_t             want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  req_t               req = '0;
  logic               done;
  rsp_t               rsp;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Shadow copy of the allocator state
  bit               shadow_held [NUM_SLOTS];
  logic [OWNER_W-1:0] shadow_owner [NUM_SLOTS];
  int               shadow_count;
  logic [CAP_W-1:0] shadow_cap;

  rsp_t      pending_rsp [$];
  stim_row_t stim_rows [$];
  int        fault_count = 0;

  unique_owner_slot_allocator DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("unique_owner_slot_allocator verification failed");
    $finish;
  end

  function automatic int active_slots();
    return (shadow_cap > NUM_SLOTS) ? NUM_SLOTS : int'(shadow_cap);
  endfunction

  function automatic void empty_table();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      shadow_held[i]  = 1'b0;
      shadow_owner[i] = '0;
    end
    shadow_count = 0;
  endfunction

  // Next result of the allocator for one operation; updates the shadow state
  function automatic rsp_t predict_alloc(req_t r);
    rsp_t o;
    int   cap;
    int   s;
    bit   dup;
    bit   placed;
    cap    = active_slots();
    o      = '0;
    o.status = STATUS_FAIL;
    dup    = 1'b0;
    placed = 1'b0;
    s      = -1;
    for (int i = 0; i < cap; i++)
      if (shadow_held[i] && shadow_owner[i] == r.owner_id) dup = 1'b1;
    case (r.func)
      FN_RSV_FIRST: begin
        if (shadow_count < cap && !dup) begin
          for (int i = 0; i < cap; i++) begin
            if (!placed && !shadow_held[i]) begin
              placed          = 1'b1;
              shadow_held[i]  = 1'b1;
              shadow_owner[i] = r.owner_id;
              shadow_count++;
              o.status      = STATUS_OK;
              o.result_slot = i[SIDX_W-1:0];
            end
          end
        end
      end
      FN_RSV_AT: begin
        if (r.slot_index < cap && !shadow_held[r.slot_index] && shadow_count < cap && !dup)
        begin
          shadow_held[r.slot_index]  = 1'b1;
          shadow_owner[r.slot_index] = r.owner_id;
          shadow_count++;
          o.status      = STATUS_OK;
          o.result_slot = r.slot_index;
        end
      end
      FN_FREE_SLOT, FN_FREE_LAST: begin
        if (r.func == FN_FREE_SLOT) s = int'(r.slot_index);
        else if (shadow_count > 0) s = shadow_count - 1;
        if (s >= 0 && s < cap && shadow_held[s]) begin
          o.status        = STATUS_OK;
          o.result_slot   = s[SIDX_W-1:0];
          o.result_owner  = shadow_owner[s];
          shadow_held[s]  = 1'b0;
          shadow_owner[s] = '0;
          shadow_count--;
        end
      end
      FN_QUERY: begin
        if (r.slot_index < cap && shadow_held[r.slot_index]) begin
          o.status       = STATUS_OK;
          o.result_slot  = r.slot_index;
          o.result_owner = shadow_owner[r.slot_index];
        end
      end
      default: ;
    endcase
    o.free_count     = CAP_W'(cap - shadow_count);
    o.occupied_count = CAP_W'(shadow_count);
    return o;
  endfunction

  // Random operation: mostly well-formed slots and a small owner pool
  function automatic req_t random_req(int cap, logic [OWNER_W-1:0] pool_base);
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      r.func = FN_RSV_FIRST;
    else if (pick < 50) r.func = FN_RSV_AT;
    else if (pick < 65) r.func = FN_FREE_SLOT;
    else if (pick < 80) r.func = FN_FREE_LAST;
    else if (pick < 95) r.func = FN_QUERY;
    else begin
      case ($urandom_range(0, 2))
        0:       r.func = FN_RSVD5;
        1:       r.func = FN_RSVD6;
        default: r.func = FN_RSVD7;
      endcase
    end
    if ($urandom_range(0, 9) == 0) r.owner_id = OWNER_W'($urandom);
    else r.owner_id = pool_base ^ OWNER_W'($urandom_range(0, cap + cap / 2 + 1));
    if (cap > 0 && $urandom_range(0, 9) < 8) r.slot_index = SIDX_W'($urandom_range(0, cap - 1));
    else r.slot_index = SIDX_W'($urandom);
    return r;
  endfunction

  function automatic stim_row_t op_row(logic [FUNC_W-1:0] f, logic [OWNER_W-1:0] own,
                                       logic [SIDX_W-1:0] slot);
    stim_row_t row;
    row.kind    = ROW_OP;
    row.cap_val = '0;
    row.op      = '{func: f, owner_id: own, slot_index: slot};
    row.typed   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  function automatic stim_row_t chk_row(logic [FUNC_W-1:0] f, logic [OWNER_W-1:0] own,
                                        logic [SIDX_W-1:0] slot, logic st,
                                        logic [SIDX_W-1:0] rs, logic [OWNER_W-1:0] ro,
                                        logic [CAP_W-1:0] fr, logic [CAP_W-1:0] oc);
    stim_row_t row;
    row       = op_row(f, own, slot);
    row.typed = 1'b1;
    row.want  = '{status: st, result_slot: rs, result_owner: ro, free_count: fr,
                  occupied_count: oc};
    return row;
  endfunction

  function automatic stim_row_t cap_row(logic [CAP_W-1:0] val);
    stim_row_t row;
    row         = op_row(FN_QUERY, '0, '0);
    row.kind    = ROW_CAP;
    row.cap_val = val;
    return row;
  endfunction

  // One start transfer; start stays high until the next call or a hold-off
  task automatic send_op(req_t r, bit typed, rsp_t want);
    rsp_t pred;
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    pred = predict_alloc(r);
    pending_rsp.push_back(typed ? want : pred);
  endtask

  // Hold off the sender until every outstanding result has arrived
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[PADDR_W-1:2] == REG_ACTIVE_CAP) begin
      shadow_cap = data[CAP_W-1:0];
      empty_table();
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cap_readback();
    logic [PDATA_W-1:0] want;
    want = PDATA_W'(shadow_cap);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CAP_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t: capacity readback expected %0d got %0d", $time, want, prdata);
      fault_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] val);
    drain_results();
    reg_write(CAP_ADDR, PDATA_W'(val));
    cap_readback();
  endtask

  task automatic cmp_field(string fname, logic [OWNER_W-1:0] want, logic [OWNER_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, fname, want, got);
      fault_count++;
    end
  endtask

  // Result checker: every strobe must match the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result expected none got %h", $time, rsp);
        fault_count++;
      end else begin
        want = pending_rsp.pop_front();
        cmp_field("status", OWNER_W'(want.status), OWNER_W'(rsp.status));
        cmp_field("result_slot", OWNER_W'(want.result_slot), OWNER_W'(rsp.result_slot));
        cmp_field("result_owner", want.result_owner, rsp.result_owner);
        cmp_field("free_count", OWNER_W'(want.free_count), OWNER_W'(rsp.free_count));
        cmp_field("occupied_count", OWNER_W'(want.occupied_count),
                  OWNER_W'(rsp.occupied_count));
      end
    end
  end

  initial begin
    logic [OWNER_W-1:0] pool_base;
    bit                 quiet;
    shadow_cap = CAP_RESET;
    empty_table();

    // Directed rows: empty table, extremes, duplicates, capacity edges
    stim_rows.push_back(chk_row(FN_QUERY, 16'h0000, 6'd0, STATUS_FAIL, 0, 0, 7'd64, 7'd0));
    stim_rows.push_back(chk_row(FN_FREE_LAST, 16'h0000, 6'd0, STATUS_FAIL, 0, 0, 7'd64, 7'd0));
    stim_rows.push_back(chk_row(FN_FREE_SLOT, 16'h0000, 6'd63, STATUS_FAIL, 0, 0, 7'd64, 7'd0));
    stim_rows.push_back(chk_row(FN_RSV_FIRST, 16'h0000, 6'd63, STATUS_OK, 0, 0, 7'd63, 7'd1));
    stim_rows.push_back(chk_row(FN_RSV_FIRST, 16'h0000, 6'd0, STATUS_FAIL, 0, 0, 7'd63, 7'd1));
    stim_rows.push_back(chk_row(FN_RSV_AT, 16'hFFFF, 6'd63, STATUS_OK, 6'd63, 0, 7'd62, 7'd2));
    stim_rows.push_back(chk_row(FN_RSV_AT, 16'h1234, 6'd63, STATUS_FAIL, 0, 0, 7'd62, 7'd2));
    stim_rows.push_back(chk_row(FN_QUERY, 16'h0000, 6'd63, STATUS_OK, 6'd63, 16'hFFFF,
                                7'd62, 7'd2));
    stim_rows.push_back(chk_row(FN_RSVD5, 16'hFFFF, 6'd63, STATUS_FAIL, 0, 0, 7'd62, 7'd2));
    stim_rows.push_back(op_row(FN_RSVD6, 16'h5A5A, 6'd0));
    stim_rows.push_back(op_row(FN_RSV_AT, 16'h0000, 6'd5));
    stim_rows.push_back(chk_row(FN_FREE_LAST, 16'h0000, 6'd0, STATUS_FAIL, 0, 0, 7'd62, 7'd2));
    stim_rows.push_back(op_row(FN_RSV_FIRST, 16'h1234, 6'd0));
    stim_rows.push_back(op_row(FN_FREE_LAST, 16'h0000, 6'd0));
    stim_rows.push_back(op_row(FN_FREE_SLOT, 16'h0000, 6'd63));
    stim_rows.push_back(op_row(FN_FREE_LAST, 16'h0000, 6'd0));
    stim_rows.push_back(op_row(FN_QUERY, 16'h0000, 6'd0));
    stim_rows.push_back(cap_row(7'd0));
    stim_rows.push_back(chk_row(FN_RSV_FIRST, 16'h0005, 6'd0, STATUS_FAIL, 0, 0, 7'd0, 7'd0));
    stim_rows.push_back(chk_row(FN_RSV_AT, 16'h0005, 6'd0, STATUS_FAIL, 0, 0, 7'd0, 7'd0));
    stim_rows.push_back(chk_row(FN_QUERY, 16'h0000, 6'd0, STATUS_FAIL, 0, 0, 7'd0, 7'd0));
    stim_rows.push_back(cap_row(7'd127));
    stim_rows.push_back(op_row(FN_RSV_AT, 16'hAAAA, 6'd63));
    stim_rows.push_back(op_row(FN_QUERY, 16'h0000, 6'd63));
    stim_rows.push_back(cap_row(7'd1));
    stim_rows.push_back(op_row(FN_RSV_FIRST, 16'h0007, 6'd0));
    stim_rows.push_back(op_row(FN_RSV_FIRST, 16'h0008, 6'd0));
    stim_rows.push_back(chk_row(FN_RSV_AT, 16'h0009, 6'd1, STATUS_FAIL, 0, 0, 7'd0, 7'd1));
    stim_rows.push_back(op_row(FN_FREE_LAST, 16'h0000, 6'd0));

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CAP) set_capacity(stim_rows[i].cap_val);
      else send_op(stim_rows[i].op, stim_rows[i].typed, stim_rows[i].want);
    end

    // Random phases, each under its own capacity setting
    for (int ph = 0; ph < PHASES; ph++) begin
      set_capacity(CAP_W'(PHASE_CAP[ph]));
      // write to an unmapped address must leave the table alone
      if (ph == 1) begin
        send_op(random_req(active_slots(), 16'h0000), 1'b0, '0);
        drain_results();
        reg_write(SPARE_ADDR, '0);
      end
      pool_base = OWNER_W'($urandom);
      quiet     = (ph == 6 || ph == 7);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (!quiet && $urandom_range(0, 99) < 9) begin
          @(negedge clk);
          start <= 1'b0;
          repeat ($urandom_range(1, 75)) @(negedge clk);
        end
        if (!quiet && $urandom_range(0, 99) < 3) drain_results();
        send_op(random_req(active_slots(), pool_base), 1'b0, '0);
      end
    end

    drain_results();
    repeat (80) @(posedge clk);
    if (fault_count == 0) begin
      $display("unique_owner_slot_allocator verification clean");
    end else begin
      $display("unique_owner_slot_allocator verification failed");
    end
    $finish;
  end

endmodule
